// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file. Both macros sample on the rising
// edge of i_clk and are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lmfr_pkg.sv =====
package lmfr_pkg;

    localparam int MAX_DISPLAYS = 8;
    localparam int BLOCK_COLS   = 8;

    // One display block: eight columns of eight rows, bit r of a column is row r.
    typedef logic [BLOCK_COLS-1:0][7:0] t_block;

    // Operation codes of a request.
    localparam logic [3:0] OP_CLEAR   = 4'd0;
    localparam logic [3:0] OP_SET_COL = 4'd1;
    localparam logic [3:0] OP_SET_DOT = 4'd2;
    localparam logic [3:0] OP_LEFT    = 4'd3;
    localparam logic [3:0] OP_RIGHT   = 4'd4;
    localparam logic [3:0] OP_UP      = 4'd5;
    localparam logic [3:0] OP_DOWN    = 4'd6;
    localparam logic [3:0] OP_REFRESH = 4'd7;
    localparam logic [3:0] OP_COMMAND = 4'd8;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NUM_DISPLAYS = 3'd0;
    localparam logic [2:0] CFG_FLIP_ORDER   = 3'd1;
    localparam logic [2:0] CFG_FLIP_X       = 3'd2;
    localparam logic [2:0] CFG_FLIP_Y       = 3'd3;
    localparam logic [2:0] CFG_SWAP_AXES    = 3'd4;
    localparam logic [2:0] CFG_AUTO_REFRESH = 3'd5;

    // Actions a block cell can perform.
    localparam logic [3:0] ACT_HOLD    = 4'd0;
    localparam logic [3:0] ACT_CLEAR   = 4'd1;
    localparam logic [3:0] ACT_SET_COL = 4'd2;
    localparam logic [3:0] ACT_SET_DOT = 4'd3;
    localparam logic [3:0] ACT_LEFT    = 4'd4;
    localparam logic [3:0] ACT_RIGHT   = 4'd5;
    localparam logic [3:0] ACT_UP      = 4'd6;
    localparam logic [3:0] ACT_DOWN    = 4'd7;
    localparam logic [3:0] ACT_RING    = 4'd8;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic [3:0] act;
        logic       rot;
        logic [2:0] wcol;
        logic [2:0] row;
        logic [7:0] value;
    } t_cell_ctrl;

endpackage

// ===== hdl/lmfr_req_if.sv =====
interface lmfr_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] operation;
    logic [5:0] column;
    logic [2:0] row;
    logic [7:0] value;
    logic       rotate;
    logic [3:0] command_address;

    modport source(
        output valid, operation, column, row, value, rotate, command_address,
        input  ready
    );
    modport sink(
        input  valid, operation, column, row, value, rotate, command_address,
        output ready
    );
endinterface

// ===== hdl/lmfr_rsp_if.sv =====
interface lmfr_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] reg_address;
    logic [7:0] reg_data;
    logic       latch;
    logic       last;

    modport source(
        output valid, reg_address, reg_data, latch, last,
        input  ready
    );
    modport sink(
        input  valid, reg_address, reg_data, latch, last,
        output ready
    );
endinterface

// ===== hdl/led_matrix_frame_refresh_top.sv =====
// Channel   Port    Dir  Carries
// request   i_req   in   operation, column, row, value, rotate, command_address
// response  o_rsp   out  reg_address, reg_data, latch, last
// config    i_cfg_* in   write enable, register index, register data
//
// A buffer edit completes in the cycle its request is accepted.
// A refresh then sends 8 * n words and a command n words (n displays used),
// one word per cycle unless stalled; the single output register sets that pace.
// A request is taken only when the previous one has loaded its last word.
// A stalled response holds the sequencer and the buffer ring in place.
// Reset is synchronous and active low; the buffer clears at once.
`include "assert_macros.svh"

module led_matrix_frame_refresh_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmfr_req_if.sink   i_req,
    lmfr_rsp_if.source o_rsp,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    // Configuration registers.
    logic [3:0] r_num_displays;
    logic       r_flip_order;
    logic       r_flip_x;
    logic       r_flip_y;
    logic       r_swap_axes;
    logic       r_auto_refresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_displays <= 4'd1;
            r_flip_order   <= 1'b0;
            r_flip_x       <= 1'b0;
            r_flip_y       <= 1'b0;
            r_swap_axes    <= 1'b0;
            r_auto_refresh <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lmfr_pkg::CFG_NUM_DISPLAYS: r_num_displays <= i_cfg_data;
                lmfr_pkg::CFG_FLIP_ORDER:   r_flip_order   <= i_cfg_data[0];
                lmfr_pkg::CFG_FLIP_X:       r_flip_x       <= i_cfg_data[0];
                lmfr_pkg::CFG_FLIP_Y:       r_flip_y       <= i_cfg_data[0];
                lmfr_pkg::CFG_SWAP_AXES:    r_swap_axes    <= i_cfg_data[0];
                lmfr_pkg::CFG_AUTO_REFRESH: r_auto_refresh <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // A display count of zero acts as one, anything above the chain length
    // acts as the full chain.
    logic [3:0] w_num_used;
    logic [2:0] w_last_disp;

    always_comb begin
        if (r_num_displays == 4'd0) begin
            w_num_used = 4'd1;
        end else if (r_num_displays > 4'(lmfr_pkg::MAX_DISPLAYS)) begin
            w_num_used = 4'(lmfr_pkg::MAX_DISPLAYS);
        end else begin
            w_num_used = r_num_displays;
        end
    end

    assign w_last_disp = 3'(w_num_used - 4'd1);

    // Sequencer state.
    logic       r_busy;
    logic       r_cmd_mode;
    logic [2:0] r_group;
    logic [2:0] r_disp;
    logic [3:0] r_cmd_addr;
    logic [7:0] r_cmd_data;

    logic       r_out_valid;
    logic [3:0] r_out_addr;
    logic [7:0] r_out_data;
    logic       r_out_latch;
    logic       r_out_last;

    logic w_accept;
    logic w_step;
    logic w_in_range;
    logic w_start_refresh;
    logic w_start_cmd;

    assign w_accept   = i_req.valid && !r_busy;
    assign w_step     = r_busy && (!r_out_valid || o_rsp.ready);
    assign w_in_range = ({1'b0, i_req.column[5:3]} < w_num_used);

    // Decode the request into a cell action and what follows it. Set column
    // and set dot outside the used columns do nothing at all.
    lmfr_pkg::t_cell_ctrl w_ctrl;

    always_comb begin
        w_ctrl.act      = lmfr_pkg::ACT_HOLD;
        w_ctrl.rot      = i_req.rotate;
        w_ctrl.wcol     = i_req.column[2:0];
        w_ctrl.row      = i_req.row;
        w_ctrl.value    = i_req.value;
        w_start_refresh = 1'b0;
        w_start_cmd     = 1'b0;
        if (w_accept) begin
            unique case (i_req.operation) inside
                lmfr_pkg::OP_CLEAR: begin
                    w_ctrl.act      = lmfr_pkg::ACT_CLEAR;
                    w_start_refresh = r_auto_refresh;
                end
                lmfr_pkg::OP_SET_COL: begin
                    if (w_in_range) begin
                        w_ctrl.act      = lmfr_pkg::ACT_SET_COL;
                        w_start_refresh = r_auto_refresh;
                    end
                end
                lmfr_pkg::OP_SET_DOT: begin
                    if (w_in_range) begin
                        w_ctrl.act      = lmfr_pkg::ACT_SET_DOT;
                        w_start_refresh = r_auto_refresh;
                    end
                end
                lmfr_pkg::OP_LEFT: begin
                    w_ctrl.act      = lmfr_pkg::ACT_LEFT;
                    w_start_refresh = r_auto_refresh;
                end
                lmfr_pkg::OP_RIGHT: begin
                    w_ctrl.act      = lmfr_pkg::ACT_RIGHT;
                    w_start_refresh = r_auto_refresh;
                end
                lmfr_pkg::OP_UP: begin
                    w_ctrl.act      = lmfr_pkg::ACT_UP;
                    w_start_refresh = r_auto_refresh;
                end
                lmfr_pkg::OP_DOWN: begin
                    w_ctrl.act      = lmfr_pkg::ACT_DOWN;
                    w_start_refresh = r_auto_refresh;
                end
                lmfr_pkg::OP_REFRESH: begin
                    w_start_refresh = 1'b1;
                end
                lmfr_pkg::OP_COMMAND: begin
                    w_start_cmd = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (w_step && !r_cmd_mode) begin
            // Each refresh word rotates the used blocks by one position, so
            // after a full group every block is back where it started.
            w_ctrl.act = lmfr_pkg::ACT_RING;
        end
    end

    // Chain of block cells. In display order the tap is the last used block and
    // the ring turns toward it; in reversed order the tap is block zero and the
    // ring turns toward block zero.
    lmfr_pkg::t_block w_blk [lmfr_pkg::MAX_DISPLAYS];
    lmfr_pkg::t_block w_tap_last;
    lmfr_pkg::t_block w_tap;

    assign w_tap_last = w_blk[w_last_disp];
    assign w_tap      = r_flip_order ? w_blk[0] : w_tap_last;

    for (genvar gb = 0; gb < lmfr_pkg::MAX_DISPLAYS; gb++) begin : g_cell
        localparam int NXT = (gb + 1) % lmfr_pkg::MAX_DISPLAYS;
        localparam int PRV = (gb + lmfr_pkg::MAX_DISPLAYS - 1) % lmfr_pkg::MAX_DISPLAYS;

        logic             w_is_last;
        logic [7:0]       w_left_in;
        logic [7:0]       w_right_in;
        lmfr_pkg::t_block w_ring_in;

        assign w_is_last = (w_last_disp == 3'(gb));

        always_comb begin
            if (w_is_last) begin
                w_left_in = w_ctrl.rot ? w_blk[0][0] : 8'd0;
            end else begin
                w_left_in = w_blk[NXT][0];
            end
            if (gb == 0) begin
                w_right_in = w_ctrl.rot ? w_tap_last[lmfr_pkg::BLOCK_COLS-1] : 8'd0;
            end else begin
                w_right_in = w_blk[PRV][lmfr_pkg::BLOCK_COLS-1];
            end
            if (r_flip_order) begin
                w_ring_in = w_is_last ? w_blk[0] : w_blk[NXT];
            end else begin
                w_ring_in = (gb == 0) ? w_tap_last : w_blk[PRV];
            end
        end

        lmfr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_used     (3'(gb) <= w_last_disp),
            .i_sel      (i_req.column[5:3] == 3'(gb)),
            .i_left_in  (w_left_in),
            .i_right_in (w_right_in),
            .i_ring_in  (w_ring_in),
            .o_block    (w_blk[gb])
        );
    end

    // Row byte of the tapped block for the current digit. With swapped axes
    // a buffer column is sent, its bits reversed under flip Y; otherwise one row
    // is gathered across the eight columns.
    logic [7:0] w_row_byte;
    logic [7:0] w_col_byte;
    logic [2:0] w_bit;

    always_comb begin
        w_col_byte = w_tap[r_flip_x ? ~r_group : r_group];
        w_bit      = r_flip_y ? r_group : ~r_group;
        if (r_swap_axes) begin
            for (int k = 0; k < 8; k++) begin
                w_row_byte[k] = r_flip_y ? w_col_byte[7-k] : w_col_byte[k];
            end
        end else begin
            for (int k = 0; k < 8; k++) begin
                w_row_byte[k] = r_flip_x ? w_tap[7-k][w_bit] : w_tap[k][w_bit];
            end
        end
    end

    logic w_word_latch;
    logic w_word_last;

    assign w_word_latch = (r_disp == w_last_disp);
    assign w_word_last  = w_word_latch && (r_cmd_mode || (r_group == 3'd7));

    // Sequencer: start on an accepted request, one word per step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_cmd_mode <= 1'b0;
            r_group    <= 3'd0;
            r_disp     <= 3'd0;
        end else if (w_accept) begin
            r_busy     <= w_start_refresh || w_start_cmd;
            r_cmd_mode <= w_start_cmd;
            r_group    <= 3'd0;
            r_disp     <= 3'd0;
        end else if (w_step) begin
            if (w_word_latch) begin
                r_disp <= 3'd0;
                if (w_word_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_group <= r_group + 3'd1;
                end
            end else begin
                r_disp <= r_disp + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd_addr <= i_req.command_address;
            r_cmd_data <= i_req.value;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_addr  <= r_cmd_mode ? r_cmd_addr : 4'({1'b0, r_group} + 4'd1);
            r_out_data  <= r_cmd_mode ? r_cmd_data : w_row_byte;
            r_out_latch <= w_word_latch;
            r_out_last  <= w_word_last;
        end
    end

    assign i_req.ready       = !r_busy;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.reg_address = r_out_addr;
    assign o_rsp.reg_data    = r_out_data;
    assign o_rsp.latch       = r_out_latch;
    assign o_rsp.last        = r_out_last;

    `ASSERT_SAME(a_disp_in_range, r_busy, r_disp <= w_last_disp, "display counter out of range")
    `ASSERT_NEXT(a_last_ends_busy, w_step && w_word_last, !r_busy, "sequencer ran past last word")
    `ASSERT_SAME(a_last_has_latch, r_out_valid && r_out_last, r_out_latch, "last word without latch")

endmodule

// ===== hdl/lmfr_cell.sv =====
// One display block of the frame buffer: eight columns. Neighbor columns
// enter at the edges for column shifts, and the whole block is reloaded
// from a neighbor while a refresh walks the ring of blocks.
module lmfr_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lmfr_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_used,
    input  logic                i_sel,
    input  logic [7:0]          i_left_in,
    input  logic [7:0]          i_right_in,
    input  lmfr_pkg::t_block    i_ring_in,
    output lmfr_pkg::t_block    o_block
);

    lmfr_pkg::t_block r_cols;
    lmfr_pkg::t_block n_cols;

    always_comb begin
        n_cols = r_cols;
        unique case (i_ctrl.act)
            lmfr_pkg::ACT_CLEAR: begin
                n_cols = '0;
            end
            lmfr_pkg::ACT_SET_COL: begin
                if (i_sel) begin
                    n_cols[i_ctrl.wcol] = i_ctrl.value;
                end
            end
            lmfr_pkg::ACT_SET_DOT: begin
                if (i_sel) begin
                    n_cols[i_ctrl.wcol][i_ctrl.row] = (i_ctrl.value != 8'd0);
                end
            end
            lmfr_pkg::ACT_LEFT: begin
                if (i_used) begin
                    for (int c = 0; c < lmfr_pkg::BLOCK_COLS - 1; c++) begin
                        n_cols[c] = r_cols[c+1];
                    end
                    n_cols[lmfr_pkg::BLOCK_COLS-1] = i_left_in;
                end
            end
            lmfr_pkg::ACT_RIGHT: begin
                if (i_used) begin
                    for (int c = 1; c < lmfr_pkg::BLOCK_COLS; c++) begin
                        n_cols[c] = r_cols[c-1];
                    end
                    n_cols[0] = i_right_in;
                end
            end
            lmfr_pkg::ACT_UP: begin
                if (i_used) begin
                    for (int c = 0; c < lmfr_pkg::BLOCK_COLS; c++) begin
                        n_cols[c] = {i_ctrl.rot & r_cols[c][0], r_cols[c][7:1]};
                    end
                end
            end
            lmfr_pkg::ACT_DOWN: begin
                if (i_used) begin
                    for (int c = 0; c < lmfr_pkg::BLOCK_COLS; c++) begin
                        n_cols[c] = {r_cols[c][6:0], i_ctrl.rot & r_cols[c][7]};
                    end
                end
            end
            lmfr_pkg::ACT_RING: begin
                if (i_used) begin
                    n_cols = i_ring_in;
                end
            end
            default: begin
                n_cols = r_cols;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= '0;
        end else begin
            r_cols <= n_cols;
        end
    end

    assign o_block = r_cols;

endmodule
